/* design/i2c_sbe_pkg.sv */
package i2c_sbe_pkg;

   typedef enum logic [1:0] {
      OP_PIN_SAMPLE = 2'd0,
      OP_LOAD_OUT   = 2'd1,
      OP_READ_IN    = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      CSR_OWN_ADDRESS  = 1'b0,
      CSR_SLAVE_ENABLE = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      EV_NONE          = 4'd0,
      EV_WRITE_ADDR    = 4'd1,
      EV_READ_ADDR     = 4'd2,
      EV_BYTE_RECEIVED = 4'd3,
      EV_SENT_ACKED    = 4'd4,
      EV_SENT_NACKED   = 4'd5,
      EV_STOP          = 4'd6,
      EV_RESTART       = 4'd7,
      EV_FOREIGN_ADDR  = 4'd8
   } ev_type;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_ADDR     = 8'b0000_0010,
      PH_ADDR_ACK = 8'b0000_0100,
      PH_WRX      = 8'b0000_1000,
      PH_WRX_ACK  = 8'b0001_0000,
      PH_TX       = 8'b0010_0000,
      PH_TX_ACK   = 8'b0100_0000,
      PH_TX_NEXT  = 8'b1000_0000
   } phase_type;

   localparam int ADDR_W     = 7;
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 5;
   localparam int HELD_W     = 6;
   localparam int BITS_W     = 4;
   localparam int WIDE_IDX_W = 9;

endpackage

/* design/i2c_slave_bus_engine_top.sv */
// Channel      | Direction | Handshake            | Payload
// req_         | in        | req_valid/req_stall  | op, scl_level, sda_level, buf_index, buf_data
// rsp_         | out       | rsp_valid/rsp_stall  | sda_pull_low, bus_event, event_byte,
//              |           |                      | host_data, bytes_held
// csr_         | in        | csr_write_enable     | csr_index, csr_data
//
// One transaction is accepted every cycle unless a result stall holds the input. Both stores
// are read as it enters the item stage; as it leaves, the bus state, the output register and
// one store entry are written, with forwarding covering a read of the entry being written.
// Reset is synchronous and clears control state and the store valid bits at once.
// A stall on the result side holds the output register and then the input.
module i2c_slave_bus_engine_top
   import i2c_sbe_pkg::*;
#(
   parameter int IN_DEPTH  = 32,
   parameter int OUT_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic                  req_scl_level,
   input  logic                  req_sda_level,
   input  logic [IDX_W-1:0]      req_buf_index,
   input  logic [BYTE_W-1:0]     req_buf_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_sda_pull_low,
   output logic [3:0]            rsp_bus_event,
   output logic [BYTE_W-1:0]     rsp_event_byte,
   output logic [BYTE_W-1:0]     rsp_host_data,
   output logic [HELD_W-1:0]     rsp_bytes_held,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [ADDR_W-1:0]     csr_data
);

   localparam int IW  = $clog2(IN_DEPTH);
   localparam int OW  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int WIW = $clog2(IN_DEPTH + 1);

   function automatic logic [OW-1:0] sel_reduce(input logic [BYTE_W-1:0] v);
      logic [WIDE_IDX_W-1:0] r;
      r = {1'b0, v};
      for (int k = 7; k >= 0; k--) begin
         if (int'(r) >= OUT_DEPTH * (2 ** k)) begin
            r = r - WIDE_IDX_W'(OUT_DEPTH * (2 ** k));
         end
      end
      return r[OW-1:0];
   endfunction

   // configuration
   logic [ADDR_W-1:0] own_addr_ff;
   logic              enable_ff;

   // item stage
   logic              accept;
   logic              b_vld_ff;
   op_type            b_op_ff;
   logic              b_scl_ff;
   logic              b_sda_ff;
   logic [IDX_W-1:0]  b_idx_ff;
   logic [BYTE_W-1:0] b_dat_ff;
   logic              adv;
   logic              b_fire;

   // bus state
   phase_type         phase_ff, phase_in;
   logic [BITS_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic              last_scl_ff, last_scl_in;
   logic              last_sda_ff, last_sda_in;
   logic [WIW-1:0]    wr_idx_ff, wr_idx_in;
   logic              drive_ff, drive_in;
   logic [BYTE_W-1:0] sel_ff, sel_in;

   // stores
   logic [BYTE_W-1:0] in_mem_ff [IN_DEPTH];
   logic [BYTE_W-1:0] out_mem_ff [OUT_DEPTH];
   logic [IN_DEPTH-1:0]  in_vld_ff;
   logic [OUT_DEPTH-1:0] out_vld_ff;
   logic [IW-1:0]     in_rd_addr;
   logic [OW-1:0]     out_rd_addr;
   logic [BYTE_W-1:0] in_rd_ff, out_rd_ff;
   logic              in_rdv_ff, out_rdv_ff;
   logic              in_fwd_ff, out_fwd_ff;
   logic [BYTE_W-1:0] in_fwd_data_ff, out_fwd_data_ff;
   logic [BYTE_W-1:0] in_rd_eff, out_rd_eff;
   logic              in_wr_en, out_wr_en;
   logic [IW-1:0]     in_wr_addr;
   logic [OW-1:0]     out_wr_addr;
   logic [BYTE_W-1:0] in_wr_data, out_wr_data;

   // results
   logic              rsp_valid_ff;
   logic              rsp_drive_ff;
   ev_type            rsp_ev_ff, ev;
   logic [BYTE_W-1:0] rsp_evb_ff, evb;
   logic [BYTE_W-1:0] rsp_hd_ff, hd;
   logic [HELD_W-1:0] rsp_held_ff;

   logic                  rise, fall, start, stop;
   logic [BYTE_W-1:0]     rx_shift;
   logic [BITS_W-1:0]     cnt_inc;
   logic [WIDE_IDX_W-1:0] req_idx_wide, b_idx_wide, wr_idx_wide;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign b_fire    = b_vld_ff && adv;
   assign req_stall = b_vld_ff && !adv;
   assign accept    = req_valid && !req_stall;

   assign rise     = !last_scl_ff && b_scl_ff;
   assign fall     = last_scl_ff && !b_scl_ff;
   assign start    = b_scl_ff && last_scl_ff && last_sda_ff && !b_sda_ff;
   assign stop     = b_scl_ff && last_scl_ff && !last_sda_ff && b_sda_ff;
   assign rx_shift = {shift_ff[BYTE_W-2:0], b_sda_ff};
   assign cnt_inc  = bit_cnt_ff + BITS_W'(1);

   assign req_idx_wide = WIDE_IDX_W'(req_buf_index);
   assign b_idx_wide   = WIDE_IDX_W'(b_idx_ff);
   assign wr_idx_wide  = WIDE_IDX_W'(wr_idx_in);
   assign in_rd_addr   = req_idx_wide[IW-1:0];
   assign out_rd_addr  = sel_reduce(sel_ff);

   assign in_rd_eff  = in_fwd_ff ? in_fwd_data_ff : (in_rdv_ff ? in_rd_ff : '0);
   assign out_rd_eff = out_fwd_ff ? out_fwd_data_ff : (out_rdv_ff ? out_rd_ff : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= ADDR_W'(8);
         enable_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:  own_addr_ff <= csr_data;
            CSR_SLAVE_ENABLE: enable_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_op_ff  <= op_type'(req_op);
         b_scl_ff <= req_scl_level;
         b_sda_ff <= req_sda_level;
         b_idx_ff <= req_buf_index;
         b_dat_ff <= req_buf_data;
      end
   end

   always_ff @(posedge clock) begin
      if (in_wr_en) begin
         in_mem_ff[in_wr_addr] <= in_wr_data;
      end
      if (accept) begin
         in_rd_ff       <= in_mem_ff[in_rd_addr];
         in_rdv_ff      <= in_vld_ff[in_rd_addr];
         in_fwd_ff      <= in_wr_en && (in_wr_addr == in_rd_addr);
         in_fwd_data_ff <= in_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (out_wr_en) begin
         out_mem_ff[out_wr_addr] <= out_wr_data;
      end
      if (accept) begin
         out_rd_ff       <= out_mem_ff[out_rd_addr];
         out_rdv_ff      <= out_vld_ff[out_rd_addr];
         out_fwd_ff      <= out_wr_en && (out_wr_addr == out_rd_addr);
         out_fwd_data_ff <= out_wr_data;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      last_scl_in = last_scl_ff;
      last_sda_in = last_sda_ff;
      wr_idx_in   = wr_idx_ff;
      drive_in    = drive_ff;
      sel_in      = sel_ff;
      ev          = EV_NONE;
      evb         = '0;
      hd          = '0;
      in_wr_en    = 1'b0;
      in_wr_addr  = '0;
      in_wr_data  = rx_shift;
      out_wr_en   = 1'b0;
      out_wr_addr = b_idx_wide[OW-1:0];
      out_wr_data = b_dat_ff;
      if (b_fire) begin
         unique case (b_op_ff)
            OP_PIN_SAMPLE: begin
               if (!enable_ff) begin
                  phase_in   = PH_IDLE;
                  bit_cnt_in = '0;
                  drive_in   = 1'b0;
               end else if (start) begin
                  if (phase_ff != PH_IDLE) begin
                     ev = EV_RESTART;
                  end
                  phase_in   = PH_ADDR;
                  bit_cnt_in = '0;
                  shift_in   = '0;
                  drive_in   = 1'b0;
               end else if (stop) begin
                  if (phase_ff != PH_IDLE) begin
                     ev = EV_STOP;
                  end
                  phase_in   = PH_IDLE;
                  bit_cnt_in = '0;
                  drive_in   = 1'b0;
               end else begin
                  unique case (phase_ff)
                     PH_IDLE: ;
                     PH_ADDR, PH_WRX: begin
                        if (rise) begin
                           shift_in   = rx_shift;
                           bit_cnt_in = cnt_inc;
                           if (cnt_inc >= BITS_W'(8)) begin
                              bit_cnt_in = '0;
                              evb        = rx_shift;
                              if (phase_ff == PH_WRX) begin
                                 ev = EV_BYTE_RECEIVED;
                                 if (wr_idx_ff < WIW'(IN_DEPTH)) begin
                                    in_wr_en   = 1'b1;
                                    in_wr_addr = wr_idx_ff[IW-1:0];
                                    wr_idx_in  = wr_idx_ff + WIW'(1);
                                    if (wr_idx_ff == WIW'(1)) begin
                                       sel_in = rx_shift;
                                    end
                                 end
                                 phase_in = PH_WRX_ACK;
                              end else if (rx_shift[BYTE_W-1:1] == own_addr_ff) begin
                                 if (rx_shift[0]) begin
                                    ev = EV_READ_ADDR;
                                 end else begin
                                    ev         = EV_WRITE_ADDR;
                                    in_wr_en   = 1'b1;
                                    in_wr_addr = '0;
                                    wr_idx_in  = WIW'(1);
                                 end
                                 phase_in = PH_ADDR_ACK;
                              end else begin
                                 ev       = EV_FOREIGN_ADDR;
                                 phase_in = PH_IDLE;
                              end
                           end
                        end
                     end
                     PH_ADDR_ACK, PH_WRX_ACK: begin
                        if (fall) begin
                           if (!drive_ff) begin
                              drive_in = 1'b1;
                           end else if (phase_ff == PH_ADDR_ACK && shift_ff[0]) begin
                              shift_in   = out_rd_eff;
                              bit_cnt_in = '0;
                              drive_in   = !out_rd_eff[BYTE_W-1];
                              phase_in   = PH_TX;
                           end else begin
                              drive_in   = 1'b0;
                              phase_in   = PH_WRX;
                              bit_cnt_in = '0;
                              shift_in   = '0;
                           end
                        end
                     end
                     PH_TX: begin
                        if (rise) begin
                           if (bit_cnt_ff < BITS_W'(8)) begin
                              bit_cnt_in = cnt_inc;
                           end
                        end else if (fall) begin
                           if (bit_cnt_ff >= BITS_W'(8)) begin
                              drive_in = 1'b0;
                              phase_in = PH_TX_ACK;
                           end else begin
                              drive_in = !shift_ff[3'd7 - bit_cnt_ff[2:0]];
                           end
                        end
                     end
                     PH_TX_ACK: begin
                        if (rise) begin
                           evb = shift_ff;
                           if (!b_sda_ff) begin
                              ev       = EV_SENT_ACKED;
                              phase_in = PH_TX_NEXT;
                           end else begin
                              ev       = EV_SENT_NACKED;
                              phase_in = PH_IDLE;
                              drive_in = 1'b0;
                           end
                        end
                     end
                     PH_TX_NEXT: begin
                        if (fall) begin
                           shift_in   = out_rd_eff;
                           bit_cnt_in = '0;
                           drive_in   = !out_rd_eff[BYTE_W-1];
                           phase_in   = PH_TX;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        drive_in = 1'b0;
                     end
                  endcase
               end
               last_scl_in = b_scl_ff;
               last_sda_in = b_sda_ff;
            end
            OP_LOAD_OUT: begin
               if (b_idx_wide < WIDE_IDX_W'(OUT_DEPTH)) begin
                  out_wr_en = 1'b1;
               end
            end
            OP_READ_IN: begin
               if (b_idx_wide < WIDE_IDX_W'(IN_DEPTH)) begin
                  hd = in_rd_eff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         last_scl_ff  <= 1'b1;
         last_sda_ff  <= 1'b1;
         wr_idx_ff    <= '0;
         drive_ff     <= 1'b0;
         sel_ff       <= '0;
         in_vld_ff    <= '0;
         out_vld_ff   <= '0;
      end else begin
         if (accept) begin
            b_vld_ff <= 1'b1;
         end else if (b_fire) begin
            b_vld_ff <= 1'b0;
         end
         if (b_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         phase_ff    <= phase_in;
         bit_cnt_ff  <= bit_cnt_in;
         shift_ff    <= shift_in;
         last_scl_ff <= last_scl_in;
         last_sda_ff <= last_sda_in;
         wr_idx_ff   <= wr_idx_in;
         drive_ff    <= drive_in;
         sel_ff      <= sel_in;
         if (in_wr_en) begin
            in_vld_ff[in_wr_addr] <= 1'b1;
         end
         if (out_wr_en) begin
            out_vld_ff[out_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_drive_ff <= drive_in;
         rsp_ev_ff    <= ev;
         rsp_evb_ff   <= evb;
         rsp_hd_ff    <= hd;
         rsp_held_ff  <= wr_idx_wide[HELD_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sda_pull_low = rsp_drive_ff;
   assign rsp_bus_event    = rsp_ev_ff;
   assign rsp_event_byte   = rsp_evb_ff;
   assign rsp_host_data    = rsp_hd_ff;
   assign rsp_bytes_held   = rsp_held_ff;

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (b_vld_ff && rsp_valid_ff))
      else $error("input stalled while the pipeline has room");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      b_fire |=> rsp_valid_ff)
      else $error("processed transaction produced no result");

   a_idle_releases_sda: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !drive_ff)
      else $error("data line driven low while idle");

   a_write_index_bound: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= WIW'(IN_DEPTH))
      else $error("write index beyond the incoming store");
`endif

endmodule
